FILE: sv/mtwg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtwg_pkg
// shared types, constants and word functions of the mt19937 word generator
// ----------------------------------------------------------------------------
package mtwg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int ADDR_W        = $clog2(STATE_WORDS);
    localparam int IDX_W         = $clog2(STATE_WORDS + 2);
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [ADDR_W-1:0] LAST_WORD      = ADDR_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0]  SEEDED_INDEX   = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0]  UNSEEDED_INDEX = IDX_W'(STATE_WORDS + 1);

    localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    typedef enum logic [0:0] {
        FUNC_GENERATE = 1'b0,
        FUNC_SEED     = 1'b1
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [31:0] seed;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_TW_INIT,
        ST_TW_LOAD,
        ST_TW_CALC,
        ST_GEN_READ,
        ST_GEN_OUT
    } t_eng_state;

    typedef struct packed {
        logic [IDX_W-1:0] read_index;
        logic             out_load;
    } t_eng_status;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] joined;
        logic [31:0] v;
        joined = {cur[31], nxt[30:0]};
        v = far ^ (joined >> 1);
        if (joined[0]) begin
            v = v ^ TWIST_XOR;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: sv/mtwg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtwg_front
// accepts commands, decodes them and holds them in a short queue
// ----------------------------------------------------------------------------
module mtwg_front #(
    parameter int DEPTH = mtwg_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // seed_value
    input  wire logic         s_axis_tuser,   // func
    output logic              o_cmd_valid,
    output mtwg_pkg::t_cmd    o_cmd,
    input  wire logic         i_cmd_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mtwg_pkg::t_cmd   r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    mtwg_pkg::t_cmd   w_cmd;

    assign s_axis_tready = (r_count != CNT_W'(DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_count != '0);
    assign o_cmd         = r_queue[r_rd_ptr];

    // decode the command kind, seed only kept for reseeds
    always_comb begin
        w_cmd.func = s_axis_tuser ? mtwg_pkg::FUNC_SEED : mtwg_pkg::FUNC_GENERATE;
        w_cmd.seed = s_axis_tuser ? s_axis_tdata : '0;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, i_cmd_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: sv/mtwg_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtwg_engine
// state store, seeding, full-store twist, tempering and output register
// ----------------------------------------------------------------------------
module mtwg_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_valid,
    input  wire mtwg_pkg::t_cmd      i_cmd,
    output logic                     o_cmd_pop,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [31:0]              m_axis_tdata,   // random_word
    output mtwg_pkg::t_eng_status    o_status
);

    localparam int AW = mtwg_pkg::ADDR_W;
    localparam int IW = mtwg_pkg::IDX_W;

    mtwg_pkg::t_eng_state r_state, n_state;

    logic [31:0]   r_mem [mtwg_pkg::STATE_WORDS];
    logic [31:0]   r_qa, r_qb;
    logic          w_we;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic [AW-1:0] w_rd_a, w_rd_b;

    logic [IW-1:0] r_read_index, n_read_index;
    logic          r_pending, n_pending;
    logic [AW-1:0] r_k, n_k;
    logic [31:0]   r_prev, n_prev;
    logic [31:0]   r_cur, n_cur;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_data, n_out_data;
    logic          w_out_free;
    logic          w_out_load;

    logic [31:0]   w_mix;
    logic [31:0]   w_seed_next;
    logic [AW-1:0] w_next_addr;
    logic [AW:0]   w_far_sum;
    logic [AW-1:0] w_far_addr;

    assign w_mix       = r_prev ^ (r_prev >> 30);
    assign w_seed_next = 32'(mtwg_pkg::SEED_MULT * w_mix) + 32'(r_k);
    assign w_next_addr = (r_k == mtwg_pkg::LAST_WORD) ? '0 : r_k + 1'b1;
    assign w_far_sum   = (AW + 1)'(r_k) + (AW + 1)'(mtwg_pkg::MIDDLE_OFFSET);
    assign w_far_addr  = (w_far_sum >= (AW + 1)'(mtwg_pkg::STATE_WORDS))
                       ? AW'(w_far_sum - (AW + 1)'(mtwg_pkg::STATE_WORDS))
                       : w_far_sum[AW-1:0];
    assign w_out_free  = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid       = r_out_valid;
    assign m_axis_tdata        = r_out_data;
    assign o_status.read_index = r_read_index;
    assign o_status.out_load   = w_out_load;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtwg_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.func == mtwg_pkg::FUNC_SEED) begin
                        n_state = mtwg_pkg::ST_SEED;
                    end else if (r_read_index == mtwg_pkg::UNSEEDED_INDEX) begin
                        n_state = mtwg_pkg::ST_SEED;
                    end else if (r_read_index >= mtwg_pkg::SEEDED_INDEX) begin
                        n_state = mtwg_pkg::ST_TW_INIT;
                    end else begin
                        n_state = mtwg_pkg::ST_GEN_READ;
                    end
                end
            end
            mtwg_pkg::ST_SEED: begin
                if (r_k == mtwg_pkg::LAST_WORD) begin
                    n_state = r_pending ? mtwg_pkg::ST_TW_INIT : mtwg_pkg::ST_IDLE;
                end
            end
            mtwg_pkg::ST_TW_INIT:  n_state = mtwg_pkg::ST_TW_LOAD;
            mtwg_pkg::ST_TW_LOAD:  n_state = mtwg_pkg::ST_TW_CALC;
            mtwg_pkg::ST_TW_CALC: begin
                n_state = (r_k == mtwg_pkg::LAST_WORD) ? mtwg_pkg::ST_GEN_READ
                                                       : mtwg_pkg::ST_TW_LOAD;
            end
            mtwg_pkg::ST_GEN_READ: n_state = mtwg_pkg::ST_GEN_OUT;
            mtwg_pkg::ST_GEN_OUT: begin
                if (w_out_free) begin
                    n_state = mtwg_pkg::ST_IDLE;
                end
            end
            default: n_state = mtwg_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_cmd_pop    = 1'b0;
        w_we         = 1'b0;
        w_wr_addr    = r_k;
        w_wr_data    = w_seed_next;
        w_rd_a       = '0;
        w_rd_b       = '0;
        w_out_load   = 1'b0;
        n_read_index = r_read_index;
        n_pending    = r_pending;
        n_k          = r_k;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        case (r_state)
            mtwg_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.func == mtwg_pkg::FUNC_SEED ||
                        r_read_index == mtwg_pkg::UNSEEDED_INDEX) begin
                        w_we      = 1'b1;
                        w_wr_addr = '0;
                        w_wr_data = (i_cmd.func == mtwg_pkg::FUNC_SEED)
                                  ? i_cmd.seed : mtwg_pkg::DEFAULT_SEED;
                        n_prev    = w_wr_data;
                        n_k       = AW'(1);
                        n_pending = (i_cmd.func != mtwg_pkg::FUNC_SEED);
                    end
                end
            end
            mtwg_pkg::ST_SEED: begin
                w_we   = 1'b1;
                n_prev = w_seed_next;
                n_k    = r_k + 1'b1;
                if (r_k == mtwg_pkg::LAST_WORD) begin
                    n_read_index = mtwg_pkg::SEEDED_INDEX;
                    n_pending    = 1'b0;
                end
            end
            mtwg_pkg::ST_TW_INIT: begin
                n_k = '0;
            end
            mtwg_pkg::ST_TW_LOAD: begin
                if (r_k == '0) begin
                    n_cur = r_qa;
                end
                w_rd_a = w_next_addr;
                w_rd_b = w_far_addr;
            end
            mtwg_pkg::ST_TW_CALC: begin
                w_we      = 1'b1;
                w_wr_data = mtwg_pkg::twist_word(r_cur, r_qa, r_qb);
                n_cur     = r_qa;
                if (r_k == mtwg_pkg::LAST_WORD) begin
                    n_read_index = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            mtwg_pkg::ST_GEN_READ: begin
                w_rd_a = r_read_index[AW-1:0];
            end
            mtwg_pkg::ST_GEN_OUT: begin
                w_rd_a = r_read_index[AW-1:0];
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_data   = mtwg_pkg::temper(r_qa);
                    n_read_index = r_read_index + 1'b1;
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mtwg_pkg::ST_IDLE;
            r_read_index <= mtwg_pkg::UNSEEDED_INDEX;
            r_pending    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_read_index <= n_read_index;
            r_pending    <= n_pending;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_out_data <= n_out_data;
    end

    // state store, one write and two registered reads per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_qa <= r_mem[w_rd_a];
        r_qb <= r_mem[w_rd_b];
    end

endmodule
`default_nettype wire

FILE: sv/mt19937_word_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mt19937_word_generator_top
// 32-bit mt19937 generator with a command stream in and a word stream out
// ----------------------------------------------------------------------------
// usage
//   s_axis carries commands: tuser selects the kind (0 generate, 1 reseed),
//   tdata holds the 32-bit seed for a reseed. a reseed gives no output,
//   a generate gives one tempered word on m_axis.
//   commands wait in a small queue, so s_axis keeps taking transfers while
//   the engine works or the output waits.
//   a reseed fills the 624-word store at one word per cycle.
//   a generate with words left goes from the queue through the read and
//   output states into the output register. when the store is used up,
//   the twist pass runs first: an init state, then a load and a calc state
//   for each word. the first generate after reset also applies seed 5489.
//   reset empties the queue and output register and marks the store
//   unseeded; the store itself is not cleared.
//   while m_axis is stalled the held word stays and the engine waits before
//   loading the next one, with the queue taking commands until full.
// ----------------------------------------------------------------------------
module mt19937_word_generator_top #(
    parameter int QUEUE_DEPTH = mtwg_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // seed_value
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // random_word
);

    logic                  w_cmd_valid;
    mtwg_pkg::t_cmd        w_cmd;
    logic                  w_cmd_pop;
    mtwg_pkg::t_eng_status w_status;

    mtwg_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    mtwg_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_status      (w_status)
    );

`ifndef SYNTHESIS
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command popped from empty queue");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output word overwritten before transfer");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.read_index <= mtwg_pkg::UNSEEDED_INDEX)
        else $error("read index out of range");

    a_reset_unseeded: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_status.read_index == mtwg_pkg::UNSEEDED_INDEX))
        else $error("store not marked unseeded after reset");
`endif

endmodule
`default_nettype wire
